// ----- rtl/u2d_pkg.sv -----
// Shared types and constants for the unsigned-to-decimal ASCII core.
// No dependencies; imported by every module of the block.
package u2d_pkg;

  localparam int NUM_DIGITS = 10;
  localparam int IDX_W      = 4;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_DIGITS - 1);
  localparam logic [5:0]       ASCII_ZERO = 6'd48;

  typedef logic [3:0]                  bcd_t;
  typedef bcd_t [NUM_DIGITS-1:0]       digits_t;

  // One converted value: digit 0 is the most significant, lead is the
  // position of the first digit to print.
  typedef struct packed {
    digits_t          digits;
    logic [IDX_W-1:0] lead;
  } u2d_entry_t;

  // Place value for a digit position, most significant position first.
  function automatic logic [29:0] dec_pow(input logic [IDX_W-1:0] pos);
    logic [29:0] p;
    case (pos)
      4'd0:    p = 30'd1000000000;
      4'd1:    p = 30'd100000000;
      4'd2:    p = 30'd10000000;
      4'd3:    p = 30'd1000000;
      4'd4:    p = 30'd100000;
      4'd5:    p = 30'd10000;
      4'd6:    p = 30'd1000;
      4'd7:    p = 30'd100;
      4'd8:    p = 30'd10;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/u2d_front.sv -----
// Front end: accepts a value and extracts one decimal digit per cycle,
// holding the last one while the queue is full. Depends on u2d_pkg; feeds u2d_queue.
module u2d_front import u2d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        push,
  output u2d_entry_t  push_entry,
  input  logic        q_full
);

  logic             busy_r;
  logic [IDX_W-1:0] step_r;
  logic [31:0]      rem_r;
  digits_t          digits_r;
  logic             started_r;
  logic [IDX_W-1:0] lead_r;

  logic [33:0]      pow;
  logic [33:0]      mult [1:9];
  bcd_t             digit;
  logic [33:0]      sub;
  logic [31:0]      rem_nxt;
  logic             last_step;
  logic             accept;

  // Compare the remainder against all nine multiples of the place value.
  always_comb begin
    pow   = {4'b0, dec_pow(step_r)};
    digit = '0;
    sub   = '0;
    for (int c = 1; c <= 9; c++) begin
      mult[c] = pow * 34'(c);
      if ({2'b0, rem_r} >= mult[c]) begin
        digit = bcd_t'(c);
        sub   = mult[c];
      end
    end
    rem_nxt = rem_r - sub[31:0];
  end

  assign last_step = (step_r == LAST_IDX);
  assign push      = busy_r && last_step && !q_full;
  assign in_tready = !busy_r || push;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    push_entry.digits           = digits_r;
    push_entry.digits[LAST_IDX] = digit;
    push_entry.lead             = lead_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (push) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step_r    <= '0;
      rem_r     <= in_tdata;
      started_r <= 1'b0;
      lead_r    <= LAST_IDX;
    end else if (busy_r && !last_step) begin
      step_r           <= step_r + 1'b1;
      rem_r            <= rem_nxt;
      digits_r[step_r] <= digit;
      if (digit != '0 && !started_r) begin
        started_r <= 1'b1;
        lead_r    <= step_r;
      end
    end
  end

endmodule

// ----- rtl/u2d_queue.sv -----
// Two-entry queue between digit extraction and character output.
// Depends on u2d_pkg for the entry type.
module u2d_queue import u2d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  u2d_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output u2d_entry_t pop_entry,
  output logic       empty
);

  u2d_entry_t mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign empty     = (count_r == 2'd0);
  assign pop_entry = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- rtl/u2d_back.sv -----
// Back end: walks one queued value from its leading digit and drives the
// output register, one character per cycle while out_tready allows. Depends on u2d_pkg.
module u2d_back import u2d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       empty,
  input  u2d_entry_t pop_entry,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [5:0] digit_char, [7:6] zero
  output logic       out_tlast
);

  logic             active_r;
  digits_t          digits_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;
  logic [5:0]       out_char_r;
  logic             out_last_r;

  logic emit;
  logic done;

  assign emit = active_r && (!out_valid_r || out_tready);
  assign done = emit && (idx_r == LAST_IDX);
  assign pop  = !empty && (!active_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (pop) begin
      active_r <= 1'b1;
    end else if (done) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      digits_r <= pop_entry.digits;
      idx_r    <= pop_entry.lead;
    end else if (emit) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= ASCII_ZERO + {2'b0, digits_r[idx_r]};
      out_last_r <= (idx_r == LAST_IDX);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b0, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/unsigned_to_decimal_ascii_core.sv -----
// Top level of the unsigned-to-decimal ASCII core.
// Depends on u2d_pkg, u2d_front, u2d_queue and u2d_back.
//
// Usage:
//   in_*  : one 32-bit unsigned value per item on in_tdata.
//   out_* : one ASCII digit per item on out_tdata[5:0], most significant
//           first, leading zeros dropped (zero prints as a single '0').
//           out_tlast marks the least significant digit of each value.
// The front end extracts one digit per cycle against a table of place
// values (ten steps per value), holding the last digit while the queue
// is full; the back end prints one character per cycle while out_tready
// is high.
// A two-entry queue of converted values sits between the two halves, so a
// new value is taken while earlier ones are still being printed, and a
// stalled receiver only stops the front end once the queue is full.
// The output is registered; out_tdata and out_tlast hold while out_tvalid
// is high and out_tready is low.
// Reset (rst_n low, synchronous) empties the queue and drops every value in
// flight; there is no other state and nothing to configure.
module unsigned_to_decimal_ascii_core import u2d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] digit_char, [7:6] zero
  output logic        out_tlast
);

  logic       q_push;
  u2d_entry_t q_push_entry;
  logic       q_full;
  logic       q_pop;
  u2d_entry_t q_pop_entry;
  logic       q_empty;

  // Digit extraction, one digit per cycle unless held by a full queue.
  u2d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push       (q_push),
    .push_entry (q_push_entry),
    .q_full     (q_full)
  );

  // Decouples the two halves.
  u2d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_pop_entry),
    .empty      (q_empty)
  );

  // Character output with registered stream port.
  u2d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (q_empty),
    .pop_entry  (q_pop_entry),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- rtl/u2d_checker.sv -----
// Port-level checks for the unsigned-to-decimal ASCII core.
// Depends on u2d_pkg; bound to unsigned_to_decimal_ascii_core below.
module u2d_checker import u2d_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic       out_acc;
  logic [3:0] run_cnt_r;

  assign out_acc = out_tvalid && out_tready;

  // Characters already sent in the current run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
    end else if (out_acc) begin
      run_cnt_r <= out_tlast ? 4'd0 : run_cnt_r + 4'd1;
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && run_cnt_r == 4'd0 && !out_tlast |-> out_tdata[5:0] != ASCII_ZERO)
    else $error("leading zero printed");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> run_cnt_r < 4'(NUM_DIGITS) &&
                (run_cnt_r != LAST_IDX || out_tlast))
    else $error("run longer than ten digits");

endmodule

bind unsigned_to_decimal_ascii_core u2d_checker u_u2d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
